@@ hw/rtl/ssp_pkg.sv @@
// Shared types, constants and divider step functions for the sprite projector.
package ssp_pkg;

   localparam int SCREEN_WIDTH  = 640;
   localparam int SCREEN_HEIGHT = 480;

   // divider sizing: numerators up to 44 bits, denominators up to 33 bits
   localparam int NUM_W = 44;
   localparam int DEN_W = 33;
   localparam int QW    = 16;
   localparam int CMP_W = DEN_W + QW;
   localparam int LANES = 3;

   // divider lane assignment
   localparam int LANE_DEPTH  = 0;
   localparam int LANE_CENTRE = 1;
   localparam int LANE_SIZE   = 2;

   // configuration register indexes
   localparam logic [2:0] REG_CAM_POS_X    = 3'd0;
   localparam logic [2:0] REG_CAM_POS_Y    = 3'd1;
   localparam logic [2:0] REG_VIEW_DIR_X   = 3'd2;
   localparam logic [2:0] REG_VIEW_DIR_Y   = 3'd3;
   localparam logic [2:0] REG_PROJ_PLANE_X = 3'd4;
   localparam logic [2:0] REG_PROJ_PLANE_Y = 3'd5;

   typedef struct packed {
      logic signed [15:0] cam_pos_x;
      logic signed [15:0] cam_pos_y;
      logic signed [15:0] view_dir_x;
      logic signed [15:0] view_dir_y;
      logic signed [15:0] proj_plane_x;
      logic signed [15:0] proj_plane_y;
   } cfg_type;

   typedef struct packed {
      logic signed [15:0] obj_x;
      logic signed [15:0] obj_y;
   } req_type;

   typedef struct packed {
      logic signed [15:0] cam_depth;
      logic signed [15:0] centre_col;
      logic [15:0]        proj_size;
      logic [11:0]        row_first;
      logic signed [15:0] row_last;
      logic [14:0]        col_first;
      logic signed [15:0] col_last;
   } rsp_type;

   typedef struct packed {
      logic det_zero;
      logic numy_zero;
      logic numx_neg;
      logic depth_neg;
      logic centre_neg;
   } flags_type;

   typedef struct packed {
      logic [NUM_W-1:0] rem;
      logic [DEN_W-1:0] den;
      logic [QW-1:0]    quo;
      logic             ovf;
   } div_type;

   // first divider stage: flags a quotient that does not fit in QW bits
   function automatic div_type div_load(logic [NUM_W-1:0] num, logic [DEN_W-1:0] den);
      logic [CMP_W:0] diff;
      div_type r;
      r.rem = num;
      r.den = den;
      r.quo = '0;
      diff  = {1'b0, CMP_W'(num)} - {1'b0, (CMP_W'(den) << QW)};
      r.ovf = ~diff[CMP_W];
      return r;
   endfunction

   // one restoring step, quotient bit k
   function automatic div_type div_step(div_type s, int k);
      logic [CMP_W:0] diff;
      div_type r;
      r    = s;
      diff = {1'b0, CMP_W'(s.rem)} - {1'b0, (CMP_W'(s.den) << k)};
      if (!diff[CMP_W]) begin
         r.rem    = diff[NUM_W-1:0];
         r.quo[k] = 1'b1;
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/ssp_front.sv @@
// Front pipeline: camera-space transform, magnitudes and divider operands.
module ssp_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  ssp_pkg::cfg_type                      cfg,
   input  logic                                  in_valid,
   input  ssp_pkg::req_type                      in_data,
   output logic                                  out_valid,
   output logic [ssp_pkg::LANES-1:0][ssp_pkg::NUM_W-1:0] out_num,
   output logic [ssp_pkg::LANES-1:0][ssp_pkg::DEN_W-1:0] out_den,
   output ssp_pkg::flags_type                    out_flags
);

   logic [5:0] v_ff;

   // stage 1: offsets
   logic signed [16:0] dx_ff, dy_ff;
   // stage 2: products
   logic signed [32:0] pa_ff, pb_ff, pc_ff, pd_ff;
   logic signed [31:0] pe_ff, pf_ff;
   // stage 3: det and numerators
   logic signed [32:0] det3_ff;
   logic signed [33:0] numx3_ff, numy3_ff;
   // stage 4: sum, flags
   logic signed [34:0] sum4_ff;
   logic signed [32:0] det4_ff;
   logic signed [33:0] numy4_ff;
   ssp_pkg::flags_type fl4_ff;
   // stage 5: magnitudes
   logic [34:0] abs_sum_ff;
   logic [32:0] abs_det_ff, abs_numy_ff;
   ssp_pkg::flags_type fl5_ff;
   // stage 6: divider operands
   logic [ssp_pkg::LANES-1:0][ssp_pkg::NUM_W-1:0] num_ff;
   logic [ssp_pkg::LANES-1:0][ssp_pkg::DEN_W-1:0] den_ff;
   ssp_pkg::flags_type fl6_ff;

   logic signed [16:0] dx_in, dy_in;
   logic signed [32:0] diry_w, dirx_w, plx_w, ply_w;
   logic signed [32:0] pa_in, pb_in, pc_in, pd_in;
   logic signed [31:0] pe_in, pf_in;
   logic signed [32:0] det3_in;
   logic signed [33:0] numx3_in, numy3_in;
   logic signed [34:0] sum4_in;
   ssp_pkg::flags_type fl4_in, fl5_in;
   logic [34:0] abs_sum_in;
   logic [32:0] abs_det_in, abs_numy_in;
   logic [ssp_pkg::LANES-1:0][ssp_pkg::NUM_W-1:0] num_in;
   logic [ssp_pkg::LANES-1:0][ssp_pkg::DEN_W-1:0] den_in;

   localparam logic [ssp_pkg::NUM_W-1:0] HALF_W_K  = ssp_pkg::NUM_W'(ssp_pkg::SCREEN_WIDTH / 2);
   localparam logic [ssp_pkg::NUM_W-1:0] HEIGHT_K  = ssp_pkg::NUM_W'(ssp_pkg::SCREEN_HEIGHT);

   always_comb begin
      dx_in = 17'(in_data.obj_x) - 17'(cfg.cam_pos_x);
      dy_in = 17'(in_data.obj_y) - 17'(cfg.cam_pos_y);

      diry_w = 33'(cfg.view_dir_y);
      dirx_w = 33'(cfg.view_dir_x);
      plx_w  = 33'(cfg.proj_plane_x);
      ply_w  = 33'(cfg.proj_plane_y);
      pa_in  = diry_w * 33'(dx_ff);
      pb_in  = dirx_w * 33'(dy_ff);
      pc_in  = plx_w * 33'(dy_ff);
      pd_in  = ply_w * 33'(dx_ff);
      pe_in  = 32'(cfg.proj_plane_x) * 32'(cfg.view_dir_y);
      pf_in  = 32'(cfg.proj_plane_y) * 32'(cfg.view_dir_x);

      det3_in  = 33'(pe_ff) - 33'(pf_ff);
      numx3_in = 34'(pa_ff) - 34'(pb_ff);
      numy3_in = 34'(pc_ff) - 34'(pd_ff);

      sum4_in           = 35'(numy3_ff) + 35'(numx3_ff);
      fl4_in.det_zero   = (det3_ff == '0);
      fl4_in.numy_zero  = (numy3_ff == '0);
      fl4_in.numx_neg   = numx3_ff[33];
      fl4_in.depth_neg  = numy3_ff[33] ^ det3_ff[32];
      fl4_in.centre_neg = 1'b0;

      abs_sum_in  = sum4_ff[34] ? 35'(-sum4_ff) : 35'(sum4_ff);
      abs_det_in  = det4_ff[32] ? 33'(-det4_ff) : 33'(det4_ff);
      abs_numy_in = numy4_ff[33] ? 33'(-numy4_ff) : 33'(numy4_ff[32:0]);
      fl5_in            = fl4_ff;
      fl5_in.centre_neg = sum4_ff[34] ^ numy4_ff[33];

      num_in[ssp_pkg::LANE_DEPTH]  = ssp_pkg::NUM_W'(abs_numy_ff) << 8;
      den_in[ssp_pkg::LANE_DEPTH]  = abs_det_ff;
      num_in[ssp_pkg::LANE_CENTRE] = ssp_pkg::NUM_W'(abs_sum_ff) * HALF_W_K;
      den_in[ssp_pkg::LANE_CENTRE] = abs_numy_ff;
      num_in[ssp_pkg::LANE_SIZE]   = ssp_pkg::NUM_W'(abs_det_ff) * HEIGHT_K;
      den_in[ssp_pkg::LANE_SIZE]   = abs_numy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff       <= dx_in;
         dy_ff       <= dy_in;
         pa_ff       <= pa_in;
         pb_ff       <= pb_in;
         pc_ff       <= pc_in;
         pd_ff       <= pd_in;
         pe_ff       <= pe_in;
         pf_ff       <= pf_in;
         det3_ff     <= det3_in;
         numx3_ff    <= numx3_in;
         numy3_ff    <= numy3_in;
         sum4_ff     <= sum4_in;
         det4_ff     <= det3_ff;
         numy4_ff    <= numy3_ff;
         fl4_ff      <= fl4_in;
         abs_sum_ff  <= abs_sum_in;
         abs_det_ff  <= abs_det_in;
         abs_numy_ff <= abs_numy_in;
         fl5_ff      <= fl5_in;
         num_ff      <= num_in;
         den_ff      <= den_in;
         fl6_ff      <= fl5_ff;
      end
   end

   assign out_valid = v_ff[5];
   assign out_num   = num_ff;
   assign out_den   = den_ff;
   assign out_flags = fl6_ff;

endmodule

@@ hw/rtl/ssp_divider.sv @@
// Three parallel pipelined restoring dividers, one quotient bit per stage.
module ssp_divider (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  in_valid,
   input  logic [ssp_pkg::LANES-1:0][ssp_pkg::NUM_W-1:0] in_num,
   input  logic [ssp_pkg::LANES-1:0][ssp_pkg::DEN_W-1:0] in_den,
   input  ssp_pkg::flags_type                    in_flags,
   output logic                                  out_valid,
   output ssp_pkg::div_type [ssp_pkg::LANES-1:0] out_res,
   output ssp_pkg::flags_type                    out_flags
);

   ssp_pkg::div_type [ssp_pkg::LANES-1:0] lane_ff [0:ssp_pkg::QW];
   ssp_pkg::flags_type                    fl_ff   [0:ssp_pkg::QW];
   logic                                  v_ff    [0:ssp_pkg::QW];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < ssp_pkg::LANES; l++) begin
            lane_ff[0][l] <= ssp_pkg::div_load(in_num[l], in_den[l]);
         end
         fl_ff[0] <= in_flags;
      end
   end

   for (genvar j = 1; j <= ssp_pkg::QW; j++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (en) begin
            v_ff[j] <= v_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            for (int l = 0; l < ssp_pkg::LANES; l++) begin
               lane_ff[j][l] <= ssp_pkg::div_step(lane_ff[j-1][l], ssp_pkg::QW - j);
            end
            fl_ff[j] <= fl_ff[j-1];
         end
      end
   end

   assign out_valid = v_ff[ssp_pkg::QW];
   assign out_res   = lane_ff[ssp_pkg::QW];
   assign out_flags = fl_ff[ssp_pkg::QW];

endmodule

@@ hw/rtl/ssp_back.sv @@
// Back end: quotient saturation, screen extents, output register and skid.
module ssp_back (
   input  logic                                  clock,
   input  logic                                  reset,
   output logic                                  en,
   input  logic                                  in_valid,
   input  ssp_pkg::div_type [ssp_pkg::LANES-1:0] in_res,
   input  ssp_pkg::flags_type                    in_flags,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output ssp_pkg::rsp_type                      rsp_data
);

   localparam logic signed [17:0] H_HALF = 18'(ssp_pkg::SCREEN_HEIGHT / 2);
   localparam logic signed [17:0] H_LAST = 18'(ssp_pkg::SCREEN_HEIGHT - 1);
   localparam logic signed [17:0] W_LAST = 18'(ssp_pkg::SCREEN_WIDTH - 1);
   localparam logic signed [17:0] COL_MIN = -18'sd32768;

   logic               b1_v_ff;
   logic signed [15:0] depth_ff, centre_ff;
   logic [15:0]        size_ff;
   logic signed [15:0] depth_in, centre_in;
   logic [15:0]        size_in;

   logic               out_v_ff, skid_v_ff;
   ssp_pkg::rsp_type   out_ff, skid_ff, res;

   logic signed [17:0] half, rf, rl, cf, cl;

   // truncating signed quotient saturated to 16 bits
   function automatic logic [15:0] sat_q(ssp_pkg::div_type d, logic neg);
      logic [15:0] r;
      if (neg) begin
         r = (d.ovf || (d.quo > 16'h8000)) ? 16'h8000 : 16'(~d.quo + 16'd1);
      end else begin
         r = (d.ovf || d.quo[15]) ? 16'h7FFF : d.quo;
      end
      return r;
   endfunction

   always_comb begin
      if (in_flags.det_zero) begin
         depth_in  = '0;
         centre_in = 16'sh7FFF;
         size_in   = 16'hFFFF;
      end else if (in_flags.numy_zero) begin
         depth_in  = '0;
         centre_in = in_flags.numx_neg ? 16'sh8000 : 16'sh7FFF;
         size_in   = 16'hFFFF;
      end else begin
         depth_in  = sat_q(in_res[ssp_pkg::LANE_DEPTH], in_flags.depth_neg);
         centre_in = sat_q(in_res[ssp_pkg::LANE_CENTRE], in_flags.centre_neg);
         size_in   = in_res[ssp_pkg::LANE_SIZE].ovf ? 16'hFFFF :
                     in_res[ssp_pkg::LANE_SIZE].quo;
      end
   end

   always_comb begin
      half = 18'({3'b000, size_ff[15:1]});
      rf   = H_HALF - half;
      rl   = H_HALF + half;
      cf   = 18'(centre_ff) - half;
      cl   = 18'(centre_ff) + half;
      if (rf < 0) rf = '0;
      if (rl > H_LAST) rl = H_LAST;
      if (cf < 0) cf = '0;
      if (cl > W_LAST) cl = W_LAST;
      if (cl < COL_MIN) cl = COL_MIN;
      res.cam_depth  = depth_ff;
      res.centre_col = centre_ff;
      res.proj_size  = size_ff;
      res.row_first  = rf[11:0];
      res.row_last   = rl[15:0];
      res.col_first  = cf[14:0];
      res.col_last   = cl[15:0];
   end

   assign en = ~skid_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_v_ff <= 1'b0;
      end else if (en) begin
         b1_v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         depth_ff  <= depth_in;
         centre_ff <= centre_in;
         size_ff   <= size_in;
      end
   end

   // output register plus one skid entry; the pipe stops only when both hold data
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (out_v_ff && rsp_ready) begin
         if (skid_v_ff) begin
            out_ff    <= skid_ff;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff <= b1_v_ff;
            out_ff   <= res;
         end
      end else if (out_v_ff) begin
         if (b1_v_ff && en) begin
            skid_ff   <= res;
            skid_v_ff <= 1'b1;
         end
      end else begin
         out_v_ff <= b1_v_ff;
         out_ff   <= res;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

endmodule

@@ hw/rtl/sprite_screen_projection.sv @@
// Sprite screen projection: config registers and pipeline top level.
//
// Usage: the camera position, view direction and projection plane sit in six
// 16-bit registers written through the csr_ port (write enable, index, data);
// write them only while no sprite is in flight. Each req_ transfer carries one
// sprite world position in Q8.8; each rsp_ transfer returns its depth, centre
// column, projected size and clipped row/column extents, in input order.
// From req_ transfer to rsp_valid a sprite passes six transform stages,
// a 17-stage divider (overflow check plus one quotient bit per stage for the
// three quotients in parallel), one saturation stage and the output register.
// Throughput is one sprite per cycle while req_ready is high; the divider
// stages set the depth. Reset clears all valid bits and loads the default
// camera (direction -1,0, plane 0,0.66). When the receiver stalls, the output
// register and one skid entry hold results; req_ready drops only once the skid
// entry is full, and the pipeline then freezes in place without dropping data.
module sprite_screen_projection (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ssp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ssp_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_wdata
);

   ssp_pkg::cfg_type cfg_ff;
   logic             en;

   logic                                  f_valid;
   logic [ssp_pkg::LANES-1:0][ssp_pkg::NUM_W-1:0] f_num;
   logic [ssp_pkg::LANES-1:0][ssp_pkg::DEN_W-1:0] f_den;
   ssp_pkg::flags_type                    f_flags;

   logic                                  d_valid;
   ssp_pkg::div_type [ssp_pkg::LANES-1:0] d_res;
   ssp_pkg::flags_type                    d_flags;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cam_pos_x    <= 16'sd0;
         cfg_ff.cam_pos_y    <= 16'sd0;
         cfg_ff.view_dir_x   <= -16'sd256;
         cfg_ff.view_dir_y   <= 16'sd0;
         cfg_ff.proj_plane_x <= 16'sd0;
         cfg_ff.proj_plane_y <= 16'sd169;
      end else if (csr_we) begin
         case (csr_index)
            ssp_pkg::REG_CAM_POS_X:    cfg_ff.cam_pos_x    <= csr_wdata;
            ssp_pkg::REG_CAM_POS_Y:    cfg_ff.cam_pos_y    <= csr_wdata;
            ssp_pkg::REG_VIEW_DIR_X:   cfg_ff.view_dir_x   <= csr_wdata;
            ssp_pkg::REG_VIEW_DIR_Y:   cfg_ff.view_dir_y   <= csr_wdata;
            ssp_pkg::REG_PROJ_PLANE_X: cfg_ff.proj_plane_x <= csr_wdata;
            ssp_pkg::REG_PROJ_PLANE_Y: cfg_ff.proj_plane_y <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_ready = en;

   ssp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (f_valid),
      .out_num   (f_num),
      .out_den   (f_den),
      .out_flags (f_flags)
   );

   ssp_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .in_num    (f_num),
      .in_den    (f_den),
      .in_flags  (f_flags),
      .out_valid (d_valid),
      .out_res   (d_res),
      .out_flags (d_flags)
   );

   ssp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_valid),
      .in_res    (d_res),
      .in_flags  (d_flags),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ tb/sprite_screen_projection_test.sv @@
// Self-checking testbench for the sprite screen projection pipeline.
module sprite_screen_projection_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY   = 25;
   localparam longint LIMIT = 400000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   ssp_pkg::req_type req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   ssp_pkg::rsp_type rsp_data;
   logic       csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   sprite_screen_projection i_dut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // camera copy used for prediction
   logic signed [15:0] cam_regs [6];
   ssp_pkg::req_type sprite_queue [$];
   ssp_pkg::rsp_type projected_queue [$];
   int        errors = 0;
   int        sent = 0;
   int        checked = 0;
   int        settings_run = 0;
   longint    cycle = 0;
   bit        hold_long = 1'b0;

   function automatic longint div_trunc_sat(longint n, longint d, longint lo, longint hi);
      longint un, ud, q;
      bit neg;
      un  = (n < 0) ? -n : n;
      ud  = (d < 0) ? -d : d;
      q   = un / ud;
      neg = (n < 0) != (d < 0);
      if (neg) return (q > -lo) ? lo : -q;
      return (q > hi) ? hi : q;
   endfunction

   function automatic ssp_pkg::rsp_type project_sprite(ssp_pkg::req_type s);
      longint px, py, dirx, diry, plx, ply, dx, dy, det, numx, numy;
      longint depth, centre, size, half, rf, rl, cf, cl, hd;
      ssp_pkg::rsp_type r;
      px   = cam_regs[ssp_pkg::REG_CAM_POS_X];
      py   = cam_regs[ssp_pkg::REG_CAM_POS_Y];
      dirx = cam_regs[ssp_pkg::REG_VIEW_DIR_X];
      diry = cam_regs[ssp_pkg::REG_VIEW_DIR_Y];
      plx  = cam_regs[ssp_pkg::REG_PROJ_PLANE_X];
      ply  = cam_regs[ssp_pkg::REG_PROJ_PLANE_Y];
      dx = longint'(s.obj_x) - px;
      dy = longint'(s.obj_y) - py;
      det  = plx * diry - ply * dirx;
      numx = diry * dx - dirx * dy;
      numy = plx * dy - ply * dx;
      if (det == 0) begin
         depth = 0; centre = 32767; size = 65535;
      end else if (numy == 0) begin
         depth = 0; centre = (numx < 0) ? -32768 : 32767; size = 65535;
      end else begin
         hd = ssp_pkg::SCREEN_HEIGHT * det;
         depth  = div_trunc_sat(numy * 256, det, -32768, 32767);
         centre = div_trunc_sat((ssp_pkg::SCREEN_WIDTH / 2) * (numy + numx), numy,
                                -32768, 32767);
         size   = div_trunc_sat(hd < 0 ? -hd : hd, numy < 0 ? -numy : numy, 0, 65535);
      end
      half = size / 2;
      rf = ssp_pkg::SCREEN_HEIGHT / 2 - half;
      if (rf < 0) rf = 0;
      rl = ssp_pkg::SCREEN_HEIGHT / 2 + half;
      if (rl >= ssp_pkg::SCREEN_HEIGHT) rl = ssp_pkg::SCREEN_HEIGHT - 1;
      cf = centre - half;
      if (cf < 0) cf = 0;
      cl = centre + half;
      if (cl >= ssp_pkg::SCREEN_WIDTH) cl = ssp_pkg::SCREEN_WIDTH - 1;
      if (cl < -32768) cl = -32768;
      r.cam_depth  = depth[15:0];
      r.centre_col = centre[15:0];
      r.proj_size  = size[15:0];
      r.row_first  = rf[11:0];
      r.row_last   = rl[15:0];
      r.col_first  = cf[14:0];
      r.col_last   = cl[15:0];
      return r;
   endfunction

   // driver: bursts and gaps; prediction made at the transfer
   int gap_left = 0;
   int burst_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            projected_queue.push_back(project_sprite(req_data));
            sent++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (sprite_queue.size() > 0) begin
               req_data  <= sprite_queue.pop_front();
               req_valid <= 1'b1;
               if (burst_left == 0) begin
                  burst_left <= $urandom_range(1, 40);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: own stall pattern plus one long hold-off
   int stall_mode = 0;
   int long_count = 0;
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle % 500 == 0) stall_mode <= $urandom_range(0, 3);
      if (hold_long && long_count < 300) begin
         long_count <= long_count + 1;
         rsp_ready  <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ready <= ($urandom_range(0, 1) != 0);
            default: rsp_ready <= (cycle % 7 < 3);
         endcase
      end
   end

   // monitor
   always @(posedge clock) begin
      ssp_pkg::rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (projected_queue.size() == 0) begin
            $error("result transfer with nothing expected");
            errors++;
         end else begin
            e = projected_queue.pop_front();
            checked++;
            if (rsp_data.cam_depth !== e.cam_depth) begin
               $error("cam_depth exp %0d got %0d", e.cam_depth, rsp_data.cam_depth); errors++;
            end
            if (rsp_data.centre_col !== e.centre_col) begin
               $error("centre_col exp %0d got %0d", e.centre_col, rsp_data.centre_col); errors++;
            end
            if (rsp_data.proj_size !== e.proj_size) begin
               $error("proj_size exp %0d got %0d", e.proj_size, rsp_data.proj_size); errors++;
            end
            if (rsp_data.row_first !== e.row_first) begin
               $error("row_first exp %0d got %0d", e.row_first, rsp_data.row_first); errors++;
            end
            if (rsp_data.row_last !== e.row_last) begin
               $error("row_last exp %0d got %0d", e.row_last, rsp_data.row_last); errors++;
            end
            if (rsp_data.col_first !== e.col_first) begin
               $error("col_first exp %0d got %0d", e.col_first, rsp_data.col_first); errors++;
            end
            if (rsp_data.col_last !== e.col_last) begin
               $error("col_last exp %0d got %0d", e.col_last, rsp_data.col_last); errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycle > LIMIT) begin
         $display("timeout after %0d cycles", cycle);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // csr_we stays high across back-to-back writes; csr_idle drops it after the last one
   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      cam_regs[idx] = val;
   endtask

   task automatic csr_idle();
      csr_we <= 1'b0;
   endtask

   task automatic drain_pipe();
      wait (sprite_queue.size() == 0);
      @(posedge clock);
      while (req_valid || projected_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_q88();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($urandom_range(0, 1024)) - 16'd512;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic add_sprite(logic [15:0] x, logic [15:0] y);
      ssp_pkg::req_type s;
      s.obj_x = x;
      s.obj_y = y;
      sprite_queue.push_back(s);
   endtask

   // positions mostly near the camera so the divisions do not all saturate
   task automatic add_random_sprites(int n);
      repeat (n) begin
         if ($urandom_range(0, 3) == 0)
            add_sprite(16'($urandom), 16'($urandom));
         else
            add_sprite(cam_regs[ssp_pkg::REG_CAM_POS_X] +
                          16'($urandom_range(0, 8191)) - 16'd4096,
                       cam_regs[ssp_pkg::REG_CAM_POS_Y] +
                          16'($urandom_range(0, 8191)) - 16'd4096);
      end
   endtask

   initial begin
      logic [15:0] vals [6];
      cam_regs[ssp_pkg::REG_CAM_POS_X]    = 16'sd0;
      cam_regs[ssp_pkg::REG_CAM_POS_Y]    = 16'sd0;
      cam_regs[ssp_pkg::REG_VIEW_DIR_X]   = -16'sd256;
      cam_regs[ssp_pkg::REG_VIEW_DIR_Y]   = 16'sd0;
      cam_regs[ssp_pkg::REG_PROJ_PLANE_X] = 16'sd0;
      cam_regs[ssp_pkg::REG_PROJ_PLANE_Y] = 16'sd169;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset camera: extremes, on-axis (zero depth numerator), behind
      add_sprite(16'h0000, 16'h0000);
      add_sprite(16'h7FFF, 16'h7FFF);
      add_sprite(16'h8000, 16'h8000);
      add_sprite(16'h7FFF, 16'h8000);
      add_sprite(16'h8000, 16'h7FFF);
      add_sprite(16'h0000, 16'h0100);
      add_sprite(16'h0000, 16'hFF00);
      add_sprite(16'hFB00, 16'h0000);
      add_sprite(16'h0500, 16'h0000);
      add_sprite(16'hFF00, 16'h0080);
      add_sprite(16'hFFFF, 16'h0001);
      add_sprite(16'hF000, 16'h0C00);
      drain_pipe();

      // zero determinant: direction parallel to plane
      write_reg(ssp_pkg::REG_VIEW_DIR_X, 16'h0100);
      write_reg(ssp_pkg::REG_VIEW_DIR_Y, 16'h0000);
      write_reg(ssp_pkg::REG_PROJ_PLANE_X, 16'h0100);
      write_reg(ssp_pkg::REG_PROJ_PLANE_Y, 16'h0000);
      csr_idle();
      add_sprite(16'h0300, 16'h0200);
      add_sprite(16'h8000, 16'h7FFF);
      drain_pipe();

      // extreme camera values
      write_reg(ssp_pkg::REG_CAM_POS_X, 16'h8000);
      write_reg(ssp_pkg::REG_CAM_POS_Y, 16'h7FFF);
      write_reg(ssp_pkg::REG_VIEW_DIR_X, 16'h7FFF);
      write_reg(ssp_pkg::REG_VIEW_DIR_Y, 16'h8000);
      write_reg(ssp_pkg::REG_PROJ_PLANE_X, 16'h8000);
      write_reg(ssp_pkg::REG_PROJ_PLANE_Y, 16'h7FFF);
      csr_idle();
      add_sprite(16'h7FFF, 16'h8000);
      add_sprite(16'h8000, 16'h7FFF);
      add_sprite(16'h0000, 16'h0000);
      drain_pipe();
      settings_run = 3;

      // long receiver hold-off with a full sender
      hold_long = 1'b1;
      add_random_sprites(80);
      drain_pipe();
      hold_long = 1'b0;

      for (int phase = 0; phase < 10; phase++) begin
         if (phase % 3 == 0) begin
            for (int i = 0; i < 6; i++) vals[i] = rand_q88();
         end else begin
            // plausible camera: unit-ish direction, perpendicular plane
            vals[ssp_pkg::REG_CAM_POS_X]  = 16'($urandom_range(0, 8191)) - 16'd4096;
            vals[ssp_pkg::REG_CAM_POS_Y]  = 16'($urandom_range(0, 8191)) - 16'd4096;
            vals[ssp_pkg::REG_VIEW_DIR_X] = 16'($urandom_range(0, 511)) - 16'd256;
            vals[ssp_pkg::REG_VIEW_DIR_Y] = 16'($urandom_range(0, 511)) - 16'd256;
            vals[ssp_pkg::REG_PROJ_PLANE_X] = -vals[ssp_pkg::REG_VIEW_DIR_Y];
            vals[ssp_pkg::REG_PROJ_PLANE_Y] = vals[ssp_pkg::REG_VIEW_DIR_X];
         end
         for (int i = 0; i < 6; i++) write_reg(3'(i), vals[i]);
         csr_idle();
         add_random_sprites(55);
         drain_pipe();
         settings_run++;
      end
      $display("covered %0d sprites over %0d camera settings, %0d results checked",
               sent, settings_run, checked);
      $display("directed extremes, zero determinant, on-axis sprites and a long output stall");
      if (errors == 0 && projected_queue.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         if (projected_queue.size() != 0)
            $error("%0d results never arrived", projected_queue.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
